@@ design/tcwr_pkg.sv @@
// Shared constants, codes and types of the topic wildcard route table.
// Used by tcwr_match, the route table unit and the bench; depends on nothing.
package tcwr_pkg;

  localparam int ROUTES   = 32;
  localparam int EXPR_LEN = 128;
  localparam int CLIENTS  = 64;

  localparam int IW  = $clog2(EXPR_LEN);
  localparam int LW  = $clog2(EXPR_LEN + 1);
  localparam int SW  = (ROUTES > 1) ? $clog2(ROUTES) : 1;
  localparam int SCW = $clog2(ROUTES + 1);
  localparam int AW  = $clog2(ROUTES * EXPR_LEN);
  localparam int CNW = 6;
  localparam int CLW = $clog2(CLIENTS);

  localparam logic [7:0] CH_STAR = 8'h2A;
  localparam logic [7:0] CH_REST = 8'h3E;
  localparam logic [7:0] CH_DOT  = 8'h2E;

  localparam logic [1:0] REQ_EXPR  = 2'd0;
  localparam logic [1:0] REQ_CLEAR = 2'd1;
  localparam logic [1:0] REQ_TOPIC = 2'd2;

  localparam logic [1:0] KIND_ADD   = 2'd0;
  localparam logic [1:0] KIND_CLEAR = 2'd1;
  localparam logic [1:0] KIND_MATCH = 2'd2;
  localparam logic [1:0] KIND_DONE  = 2'd3;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_FULL    = 2'd1;
  localparam logic [1:0] ST_TOOLONG = 2'd2;

  typedef struct packed {
    logic done;
    logic hit;
  } match_res_t;

  typedef struct packed {
    logic [1:0]     kind;
    logic [1:0]     status;
    logic [5:0]     client;
    logic [31:0]    rid;
    logic [CNW-1:0] count;
    logic           last;
  } out_t;

  function automatic out_t mk_out(logic [1:0] kind, logic [1:0] status,
                                  logic [5:0] client, logic [31:0] rid,
                                  logic [CNW-1:0] count, logic last);
    out_t o;
    o.kind   = kind;
    o.status = status;
    o.client = client;
    o.rid    = rid;
    o.count  = count;
    o.last   = last;
    return o;
  endfunction

endpackage

@@ design/tcwr_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
module tcwr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

@@ design/tcwr_match.sv @@
// Wildcard matcher: walks one stored expression against the buffered topic,
// each step waiting on the registered RAM reads before it evaluates. Uses tcwr_pkg.
module tcwr_match import tcwr_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [LW-1:0] topic_len_i,
  input  logic [LW-1:0] expr_len_i,
  input  logic [7:0]    topic_byte_i,
  input  logic [7:0]    expr_byte_i,
  output logic [IW-1:0] t_idx_o,
  output logic [IW-1:0] e_idx_o,
  output match_res_t    res_o
);

  typedef enum logic [1:0] {M_IDLE, M_WAIT, M_EVAL} mst_e;
  typedef enum logic [2:0] {P_LOOP, P_STAR, P_REST, P_RUN, P_CMP} phase_e;

  mst_e          st_q, st_d;
  phase_e        ph_q, ph_d;
  logic [IW-1:0] t_q, t_d, e_q, e_d;
  match_res_t    res_q, res_d;
  logic [7:0]    tc, ec;
  logic          both_end;

  assign tc = (LW'(t_q) < topic_len_i && LW'(t_q) < LW'(EXPR_LEN - 1)) ? topic_byte_i : 8'd0;
  assign ec = (LW'(e_q) < expr_len_i) ? expr_byte_i : 8'd0;
  assign both_end = (tc == 8'd0) && (ec == 8'd0);

  always_comb begin
    st_d  = st_q;
    ph_d  = ph_q;
    t_d   = t_q;
    e_d   = e_q;
    res_d = '{done: 1'b0, hit: res_q.hit};
    unique case (st_q)
      M_IDLE: begin
        if (start_i) begin
          t_d  = '0;
          e_d  = '0;
          ph_d = P_LOOP;
          st_d = M_WAIT;
        end
      end
      M_WAIT: begin
        st_d = M_EVAL;
      end
      M_EVAL: begin
        st_d = M_WAIT;
        unique case (ph_q)
          P_LOOP: begin
            if (tc == 8'd0 || ec == 8'd0) begin
              res_d = '{done: 1'b1, hit: both_end};
              st_d  = M_IDLE;
            end else if (ec == CH_STAR) begin
              ph_d = P_STAR;
            end else begin
              ph_d = P_REST;
            end
          end
          P_STAR: begin
            if (tc != 8'd0 && tc != CH_DOT) begin
              t_d = t_q + IW'(1);
            end else begin
              e_d  = e_q + IW'(1);
              ph_d = P_REST;
            end
          end
          P_REST: begin
            ph_d = (ec == CH_REST) ? P_RUN : P_CMP;
          end
          P_RUN: begin
            if (tc != 8'd0) begin
              t_d = t_q + IW'(1);
            end else begin
              e_d  = e_q + IW'(1);
              ph_d = P_CMP;
            end
          end
          P_CMP: begin
            if (both_end || tc != ec) begin
              res_d = '{done: 1'b1, hit: both_end};
              st_d  = M_IDLE;
            end else begin
              t_d  = t_q + IW'(1);
              e_d  = e_q + IW'(1);
              ph_d = P_LOOP;
            end
          end
          default: begin
            st_d = M_IDLE;
          end
        endcase
      end
      default: begin
        st_d = M_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q  <= M_IDLE;
      ph_q  <= P_LOOP;
      res_q <= '0;
      t_q   <= '0;
      e_q   <= '0;
    end else begin
      st_q  <= st_d;
      ph_q  <= ph_d;
      res_q <= res_d;
      t_q   <= t_d;
      e_q   <= e_d;
    end
  end

  assign t_idx_o = t_q;
  assign e_idx_o = e_q;
  assign res_o   = res_q;

endmodule

@@ design/topic_wildcard_route_table_unit.sv @@
// Topic wildcard route table: sequencer, slot registers and RAM instances.
// Uses tcwr_pkg, tcwr_ram and tcwr_match.
// An add finishing in a free slot copies the expression into the route store.
// A lookup starts the matcher on every valid route, skips free slots and hands
// off a result for each match; the matcher waits on its registered RAM reads.
// Reset clears the slot valid bits, pending and topic lengths and output valid;
// no clearing pass runs.
module topic_wildcard_route_table_unit import tcwr_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,  // char_byte, client_id, sub_id, zero fill
  input  logic [1:0]  s_axis_tuser,  // req_type
  input  logic        s_axis_tlast,  // last_char
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,  // status, match_client, match_sub_id, match_count, zero fill
  output logic [1:0]  m_axis_tuser,  // result_kind
  output logic        m_axis_tlast   // last_result
);

  typedef enum logic [2:0] {S_IDLE, S_COPY, S_SCAN, S_MWAIT, S_EMIT} state_e;

  state_e         state_q, state_d;
  logic [LW-1:0]  pend_len_q, pend_len_d, topic_len_q, topic_len_d, cp_q, cp_d;
  logic           ovf_q, ovf_d, wv_q, wv_d;
  logic [IW-1:0]  widx_q, widx_d;
  logic [ROUTES-1:0] valid_q, valid_d;
  logic [LW-1:0]  elen_q   [ROUTES];
  logic [CLW-1:0] client_q [ROUTES];
  logic [31:0]    rid_q    [ROUTES];
  logic [SW-1:0]  slot_q, slot_d;
  logic [CLW-1:0] nclient_q, nclient_d;
  logic [31:0]    nrid_q, nrid_d;
  logic [SCW-1:0] scan_q, scan_d;
  logic [CNW-1:0] count_q, count_d;
  logic           ovalid_q, ovalid_d;
  out_t           out_q, out_d;
  logic           slot_wr, pend_we, topic_we, mstart, out_free, in_acc, free_any;
  logic [SW-1:0]  free_idx, sidx;
  logic [7:0]     in_char, pend_rdata, topic_rdata, expr_rdata;
  logic [CLW-1:0] in_client;
  logic [31:0]    in_rid;
  logic [IW-1:0]  t_idx, e_idx;
  match_res_t     mres;

  assign in_char   = s_axis_tdata[7:0];
  assign in_client = s_axis_tdata[13:8];
  assign in_rid    = s_axis_tdata[45:14];
  assign out_free  = !ovalid_q || m_axis_tready;
  assign s_axis_tready = (state_q == S_IDLE) && out_free;
  assign in_acc    = s_axis_tvalid && s_axis_tready;
  assign sidx      = scan_q[SW-1:0];

  always_comb begin
    free_any = 1'b0;
    free_idx = '0;
    for (int i = ROUTES - 1; i >= 0; i--) begin
      if (!valid_q[i]) begin
        free_any = 1'b1;
        free_idx = SW'(i);
      end
    end
  end

  tcwr_ram #(.WIDTH(8), .DEPTH(EXPR_LEN)) u_pend_ram (
    .clk_i   (clk_i),
    .we_i    (pend_we),
    .waddr_i (pend_len_q[IW-1:0]),
    .wdata_i (in_char),
    .raddr_i (cp_q[IW-1:0]),
    .rdata_o (pend_rdata)
  );

  tcwr_ram #(.WIDTH(8), .DEPTH(EXPR_LEN)) u_topic_ram (
    .clk_i   (clk_i),
    .we_i    (topic_we),
    .waddr_i (topic_len_q[IW-1:0]),
    .wdata_i (in_char),
    .raddr_i (t_idx),
    .rdata_o (topic_rdata)
  );

  tcwr_ram #(.WIDTH(8), .DEPTH(ROUTES * EXPR_LEN)) u_expr_ram (
    .clk_i   (clk_i),
    .we_i    (wv_q),
    .waddr_i (AW'(slot_q) * AW'(EXPR_LEN) + AW'(widx_q)),
    .wdata_i (pend_rdata),
    .raddr_i (AW'(sidx) * AW'(EXPR_LEN) + AW'(e_idx)),
    .rdata_o (expr_rdata)
  );

  tcwr_match u_match (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (mstart),
    .topic_len_i  (topic_len_q),
    .expr_len_i   (elen_q[sidx]),
    .topic_byte_i (topic_rdata),
    .expr_byte_i  (expr_rdata),
    .t_idx_o      (t_idx),
    .e_idx_o      (e_idx),
    .res_o        (mres)
  );

  always_comb begin
    state_d     = state_q;
    pend_len_d  = pend_len_q;
    topic_len_d = topic_len_q;
    cp_d        = cp_q;
    ovf_d       = ovf_q;
    wv_d        = 1'b0;
    widx_d      = widx_q;
    valid_d     = valid_q;
    slot_d      = slot_q;
    nclient_d   = nclient_q;
    nrid_d      = nrid_q;
    scan_d      = scan_q;
    count_d     = count_q;
    ovalid_d    = ovalid_q && !m_axis_tready;
    out_d       = out_q;
    slot_wr     = 1'b0;
    pend_we     = 1'b0;
    topic_we    = 1'b0;
    mstart      = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          unique case (s_axis_tuser)
            REQ_EXPR: begin
              if (pend_len_q < LW'(EXPR_LEN - 1)) begin
                pend_we    = 1'b1;
                pend_len_d = pend_len_q + LW'(1);
              end else begin
                ovf_d = 1'b1;
              end
              if (s_axis_tlast) begin
                if (ovf_d) begin
                  ovalid_d   = 1'b1;
                  out_d      = mk_out(KIND_ADD, ST_TOOLONG, '0, '0, '0, 1'b1);
                  pend_len_d = '0;
                  ovf_d      = 1'b0;
                end else if (!free_any) begin
                  ovalid_d   = 1'b1;
                  out_d      = mk_out(KIND_ADD, ST_FULL, '0, '0, '0, 1'b1);
                  pend_len_d = '0;
                end else begin
                  slot_d    = free_idx;
                  nclient_d = in_client;
                  nrid_d    = in_rid;
                  cp_d      = '0;
                  state_d   = S_COPY;
                end
              end
            end
            REQ_CLEAR: begin
              for (int i = 0; i < ROUTES; i++) begin
                if (client_q[i] == in_client) begin
                  valid_d[i] = 1'b0;
                end
              end
              ovalid_d = 1'b1;
              out_d    = mk_out(KIND_CLEAR, ST_OK, '0, '0, '0, 1'b1);
            end
            REQ_TOPIC: begin
              topic_we = topic_len_q < LW'(EXPR_LEN - 1);
              if (topic_len_q < LW'(EXPR_LEN)) begin
                topic_len_d = topic_len_q + LW'(1);
              end
              if (s_axis_tlast) begin
                if (topic_len_d >= LW'(EXPR_LEN)) begin
                  ovalid_d    = 1'b1;
                  out_d       = mk_out(KIND_DONE, ST_TOOLONG, '0, '0, '0, 1'b1);
                  topic_len_d = '0;
                end else begin
                  scan_d  = '0;
                  count_d = '0;
                  state_d = S_SCAN;
                end
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_COPY: begin
        if (cp_q < pend_len_q) begin
          cp_d   = cp_q + LW'(1);
          wv_d   = 1'b1;
          widx_d = cp_q[IW-1:0];
        end else if (!wv_q && out_free) begin
          slot_wr         = 1'b1;
          valid_d[slot_q] = 1'b1;
          ovalid_d        = 1'b1;
          out_d           = mk_out(KIND_ADD, ST_OK, '0, '0, '0, 1'b1);
          pend_len_d      = '0;
          ovf_d           = 1'b0;
          state_d         = S_IDLE;
        end
      end
      S_SCAN: begin
        if (scan_q == SCW'(ROUTES)) begin
          if (out_free) begin
            ovalid_d    = 1'b1;
            out_d       = mk_out(KIND_DONE, ST_OK, '0, '0, count_q, 1'b1);
            topic_len_d = '0;
            state_d     = S_IDLE;
          end
        end else if (!valid_q[sidx]) begin
          scan_d = scan_q + SCW'(1);
        end else begin
          mstart  = 1'b1;
          state_d = S_MWAIT;
        end
      end
      S_MWAIT: begin
        if (mres.done) begin
          if (mres.hit) begin
            state_d = S_EMIT;
          end else begin
            scan_d  = scan_q + SCW'(1);
            state_d = S_SCAN;
          end
        end
      end
      S_EMIT: begin
        if (out_free) begin
          ovalid_d = 1'b1;
          out_d    = mk_out(KIND_MATCH, ST_OK, 6'(client_q[sidx]), rid_q[sidx], '0, 1'b0);
          count_d  = count_q + CNW'(1);
          scan_d   = scan_q + SCW'(1);
          state_d  = S_SCAN;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      pend_len_q  <= '0;
      topic_len_q <= '0;
      cp_q        <= '0;
      ovf_q       <= 1'b0;
      wv_q        <= 1'b0;
      valid_q     <= '0;
      scan_q      <= '0;
      count_q     <= '0;
      ovalid_q    <= 1'b0;
    end else begin
      state_q     <= state_d;
      pend_len_q  <= pend_len_d;
      topic_len_q <= topic_len_d;
      cp_q        <= cp_d;
      ovf_q       <= ovf_d;
      wv_q        <= wv_d;
      valid_q     <= valid_d;
      scan_q      <= scan_d;
      count_q     <= count_d;
      ovalid_q    <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    widx_q    <= widx_d;
    slot_q    <= slot_d;
    nclient_q <= nclient_d;
    nrid_q    <= nrid_d;
    out_q     <= out_d;
    if (slot_wr) begin
      elen_q[slot_q]   <= pend_len_q;
      client_q[slot_q] <= nclient_q;
      rid_q[slot_q]    <= nrid_q;
    end
  end

  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tuser  = out_q.kind;
  assign m_axis_tlast  = out_q.last;
  assign m_axis_tdata  = {2'b00, out_q.count, out_q.rid, out_q.client, out_q.status};

  a_done_in_wait : assert property (@(posedge clk_i) disable iff (!rst_ni)
    mres.done |-> state_q == S_MWAIT)
    else $error("matcher finished outside a route walk");

  a_scan_topic_len : assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_SCAN |-> topic_len_q < LW'(EXPR_LEN))
    else $error("lookup started on an overlong topic");

  a_match_not_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ovalid_q && out_q.kind == KIND_MATCH) |-> !out_q.last)
    else $error("route match marked as final result");

  a_copy_slot_free : assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_COPY |-> !valid_q[slot_q])
    else $error("expression copied into an occupied slot");

  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNW'(ROUTES))
    else $error("match count beyond route capacity");

endmodule

@@ bench/topic_wildcard_route_table_unit_tb.sv @@
// Self-checking testbench for topic_wildcard_route_table_unit.
// It runs a directed table and then random request streams against a local
// route table predictor, and needs tcwr_pkg and the unit.
`timescale 1ns / 100ps

module topic_wildcard_route_table_unit_tb;
  import tcwr_pkg::*;

  localparam logic [1:0] REQ_UNUSED = 2'd3;
  localparam int REQ_TARGET = 180;
  localparam int CYCLE_LIMIT = 5000000;
  localparam int DIR_ROWS = 16;

  typedef struct {
    logic [1:0]  req;
    logic [7:0]  ch;
    logic        last;
    logic [5:0]  client;
    logic [31:0] rid;
    bit          typed;
    logic [1:0]  kind;
    logic [1:0]  status;
  } dir_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata = '0;
  logic [1:0]  s_axis_tuser = '0;
  logic        s_axis_tlast = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [47:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;
  logic        m_axis_tlast;

  logic [7:0]  route_text [ROUTES][EXPR_LEN];
  int          route_len [ROUTES];
  bit          route_used [ROUTES];
  logic [5:0]  route_owner [ROUTES];
  logic [31:0] route_sub [ROUTES];
  logic [7:0]  expr_buf [EXPR_LEN];
  int          expr_fill;
  bit          expr_over;
  logic [7:0]  topic_text [EXPR_LEN];
  int          topic_fill;

  out_t        awaited_results [$];
  dir_row_t    dir_rows [DIR_ROWS];
  int          fail_count = 0;
  int          req_count = 0;
  int          cycle_count = 0;
  bit          tx_steady = 1'b0;
  bit          rx_steady = 1'b0;
  int          rx_hold = 0;

  topic_wildcard_route_table_unit uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [7:0] topic_char(int i);
    return (i < topic_fill) ? topic_text[i] : 8'h00;
  endfunction

  function automatic logic [7:0] route_char(int s, int i);
    return (i < route_len[s]) ? route_text[s][i] : 8'h00;
  endfunction

  function automatic bit route_matches(int s);
    int t;
    int e;
    t = 0;
    e = 0;
    while (topic_char(t) != 8'h00 && route_char(s, e) != 8'h00) begin
      if (route_char(s, e) == CH_STAR) begin
        while (topic_char(t) != 8'h00 && topic_char(t) != CH_DOT) t++;
        e++;
      end
      if (route_char(s, e) == CH_REST) begin
        while (topic_char(t) != 8'h00) t++;
        e++;
      end
      if (topic_char(t) == 8'h00 && route_char(s, e) == 8'h00) break;
      if (topic_char(t) != route_char(s, e)) break;
      t++;
      e++;
    end
    return topic_char(t) == 8'h00 && route_char(s, e) == 8'h00;
  endfunction

  function automatic void route_table_step(logic [1:0] req, logic [7:0] ch, logic last,
                                           logic [5:0] client, logic [31:0] rid,
                                           ref out_t res [$]);
    int s;
    int hits;
    logic [1:0] st;
    res = {};
    if (req == REQ_EXPR) begin
      if (expr_fill < EXPR_LEN - 1) begin
        expr_buf[expr_fill] = ch;
        expr_fill++;
      end else begin
        expr_over = 1'b1;
      end
      if (!last) return;
      st = ST_OK;
      if (expr_over) begin
        st = ST_TOOLONG;
      end else begin
        for (s = 0; s < ROUTES; s++) if (!route_used[s]) break;
        if (s >= ROUTES) begin
          st = ST_FULL;
        end else begin
          for (int i = 0; i < expr_fill; i++) route_text[s][i] = expr_buf[i];
          route_len[s] = expr_fill;
          route_used[s] = 1'b1;
          route_owner[s] = client;
          route_sub[s] = rid;
        end
      end
      expr_fill = 0;
      expr_over = 1'b0;
      res.push_back(mk_out(KIND_ADD, st, '0, '0, '0, 1'b1));
    end else if (req == REQ_CLEAR) begin
      for (s = 0; s < ROUTES; s++)
        if (route_used[s] && route_owner[s] == client) route_used[s] = 1'b0;
      res.push_back(mk_out(KIND_CLEAR, ST_OK, '0, '0, '0, 1'b1));
    end else if (req == REQ_TOPIC) begin
      if (topic_fill < EXPR_LEN - 1) topic_text[topic_fill] = ch;
      if (topic_fill < EXPR_LEN) topic_fill++;
      if (!last) return;
      if (topic_fill >= EXPR_LEN) begin
        topic_fill = 0;
        res.push_back(mk_out(KIND_DONE, ST_TOOLONG, '0, '0, '0, 1'b1));
        return;
      end
      hits = 0;
      for (s = 0; s < ROUTES; s++) begin
        if (route_used[s] && route_matches(s)) begin
          res.push_back(mk_out(KIND_MATCH, ST_OK, route_owner[s], route_sub[s], '0, 1'b0));
          hits++;
        end
      end
      res.push_back(mk_out(KIND_DONE, ST_OK, '0, '0, CNW'(hits), 1'b1));
      topic_fill = 0;
    end
  endfunction

  task automatic send_req(input logic [1:0] req, input logic [7:0] ch, input logic last,
                          input logic [5:0] client, input logic [31:0] rid,
                          input bit typed, input out_t typed_res);
    out_t res [$];
    int gap;
    gap = tx_steady ? 0 : idle_len();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {2'b00, rid, client, ch};
    s_axis_tuser  <= req;
    s_axis_tlast  <= last;
    do @(posedge clk_i); while (!s_axis_tready);
    route_table_step(req, ch, last, client, rid, res);
    if (typed && res.size() > 0) awaited_results.push_back(typed_res);
    else foreach (res[i]) awaited_results.push_back(res[i]);
    if (req != REQ_UNUSED) req_count++;
  endtask

  function automatic logic [7:0] pick_char();
    logic [7:0] alphabet [5];
    alphabet = '{8'h61, 8'h62, CH_DOT, CH_STAR, CH_REST};
    if ($urandom_range(0, 99) < 75) return alphabet[$urandom_range(0, 4)];
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic send_string(input logic [1:0] req, input int len, input logic [5:0] client,
                             input logic [31:0] rid);
    out_t none;
    none = '0;
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(0, 99) < 4)
        send_req(REQ_CLEAR, 8'($urandom), 1'b0, 6'($urandom_range(0, 7)), $urandom, 0, none);
      send_req(req, pick_char(), i == len - 1, client, rid, 0, none);
    end
  endtask

  always @(posedge clk_i) begin
    if ($urandom_range(0, 199) == 0) rx_steady <= !rx_steady;
    if (rx_hold > 0) begin
      rx_hold <= rx_hold - 1;
      m_axis_tready <= 1'b0;
    end else if (!rx_steady && $urandom_range(0, 3) == 0) begin
      rx_hold <= idle_len();
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    out_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (awaited_results.size() == 0) begin
        $display("%0t: unexpected result tuser=%0d tdata=%h tlast=%b", $time, m_axis_tuser,
                 m_axis_tdata, m_axis_tlast);
        fail_count++;
      end else begin
        want = awaited_results.pop_front();
        if (m_axis_tuser != want.kind || m_axis_tdata[1:0] != want.status ||
            m_axis_tdata[7:2] != want.client || m_axis_tdata[39:8] != want.rid ||
            m_axis_tdata[45:40] != want.count || m_axis_tlast != want.last) begin
          $display("%0t: mismatch expected kind=%0d status=%0d client=%0d id=%h count=%0d last=%b",
                   $time, want.kind, want.status, want.client, want.rid, want.count, want.last);
          $display("%0t:           actual kind=%0d status=%0d client=%0d id=%h count=%0d last=%b",
                   $time, m_axis_tuser, m_axis_tdata[1:0], m_axis_tdata[7:2],
                   m_axis_tdata[39:8], m_axis_tdata[45:40], m_axis_tlast);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[topic_wildcard_route_table_unit] ERROR");
      $finish;
    end
  end

  initial begin
    int pick;
    out_t row_res;
    for (int s = 0; s < ROUTES; s++) route_used[s] = 1'b0;
    expr_fill = 0;
    expr_over = 1'b0;
    topic_fill = 0;
    dir_rows = '{
      '{REQ_CLEAR,  8'h00, 1'b1, 6'd0,  32'h0,        1, KIND_CLEAR, ST_OK},
      '{REQ_TOPIC,  8'h78, 1'b1, 6'd0,  32'h0,        1, KIND_DONE,  ST_OK},
      '{REQ_EXPR,   CH_STAR, 1'b1, 6'd63, 32'hFFFFFFFF, 1, KIND_ADD, ST_OK},
      '{REQ_EXPR,   CH_REST, 1'b1, 6'd0,  32'h0,        1, KIND_ADD, ST_OK},
      '{REQ_EXPR,   8'h61, 1'b0, 6'd5,  32'h12345678, 0, KIND_ADD,   ST_OK},
      '{REQ_EXPR,   CH_DOT, 1'b0, 6'd5, 32'h12345678, 0, KIND_ADD,   ST_OK},
      '{REQ_EXPR,   8'h62, 1'b1, 6'd5,  32'h12345678, 1, KIND_ADD,   ST_OK},
      '{REQ_UNUSED, 8'hFF, 1'b1, 6'd63, 32'hFFFFFFFF, 0, KIND_ADD,   ST_OK},
      '{REQ_EXPR,   8'h00, 1'b1, 6'd9,  32'hA5A5A5A5, 1, KIND_ADD,   ST_OK},
      '{REQ_TOPIC,  8'h61, 1'b0, 6'd0,  32'h0,        0, KIND_DONE,  ST_OK},
      '{REQ_TOPIC,  CH_DOT, 1'b0, 6'd0, 32'h0,        0, KIND_DONE,  ST_OK},
      '{REQ_TOPIC,  8'h62, 1'b1, 6'd0,  32'h0,        0, KIND_DONE,  ST_OK},
      '{REQ_TOPIC,  8'hFF, 1'b1, 6'd0,  32'h0,        0, KIND_DONE,  ST_OK},
      '{REQ_TOPIC,  8'h00, 1'b1, 6'd0,  32'h0,        0, KIND_DONE,  ST_OK},
      '{REQ_CLEAR,  8'h00, 1'b1, 6'd63, 32'h0,        1, KIND_CLEAR, ST_OK},
      '{REQ_CLEAR,  8'h00, 1'b1, 6'd5,  32'h0,        1, KIND_CLEAR, ST_OK}
    };
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i]) begin
      row_res = mk_out(dir_rows[i].kind, dir_rows[i].status, '0, '0, '0, 1'b1);
      send_req(dir_rows[i].req, dir_rows[i].ch, dir_rows[i].last, dir_rows[i].client,
               dir_rows[i].rid, dir_rows[i].typed, row_res);
    end

    tx_steady = 1'b1;
    for (int k = 0; k < ROUTES + 2; k++)
      send_string(REQ_EXPR, $urandom_range(1, 3), 6'($urandom_range(0, 7)), $urandom);
    send_string(REQ_TOPIC, 3, 6'd0, 32'h0);
    tx_steady = 1'b0;
    for (int c = 0; c < 8; c++) send_string(REQ_CLEAR, 1, 6'(c), 32'h0);

    while (req_count < REQ_TARGET) begin
      if ($urandom_range(0, 39) == 0) tx_steady = !tx_steady;
      pick = $urandom_range(0, 99);
      if (pick < 45)
        send_string(REQ_EXPR, $urandom_range(1, 6),
                    ($urandom_range(0, 3) == 0) ? 6'($urandom) : 6'($urandom_range(0, 7)),
                    $urandom);
      else if (pick < 85)
        send_string(REQ_TOPIC, $urandom_range(1, 6), 6'($urandom), $urandom);
      else if (pick < 93)
        send_string(REQ_CLEAR, 1, 6'($urandom_range(0, 7)), $urandom);
      else if (pick < 96)
        send_string(REQ_UNUSED, 1, 6'($urandom), $urandom);
      else if (pick < 98)
        send_string(REQ_EXPR, $urandom_range(126, 130), 6'($urandom), $urandom);
      else
        send_string(REQ_TOPIC, $urandom_range(126, 130), 6'($urandom), $urandom);
    end
    s_axis_tvalid <= 1'b0;

    while (awaited_results.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    if (fail_count == 0 && awaited_results.size() == 0) begin
      $display("[topic_wildcard_route_table_unit] OK");
    end else begin
      $display("[topic_wildcard_route_table_unit] ERROR");
    end
    $finish;
  end

endmodule

@@ sim.f @@
design/tcwr_pkg.sv
design/tcwr_ram.sv
design/tcwr_match.sv
design/topic_wildcard_route_table_unit.sv
bench/topic_wildcard_route_table_unit_tb.sv
